### sv/rws_pkg.sv
// Shared constants, request codes, state encoding and control structs
// for the roulette wheel selector. No dependencies.

package rws_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = IDX_W + 1;
    localparam int FIT_W       = 16;
    localparam int TOT_W       = FIT_W + IDX_W;
    localparam int RAND_W      = 32;
    localparam int PROD_W      = RAND_W + TOT_W;
    localparam int PICK_W      = 6;
    localparam int REQ_W       = 2;
    localparam int IN_DATA_W   = 48;
    localparam int OUT_DATA_W  = 8;

    typedef enum logic [REQ_W-1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_APPEND = 2'd1,
        REQ_SELECT = 2'd2
    } req_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    typedef struct packed {
        logic clear;
        logic append;
        logic start;
        logic scan;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic exhausted;
        logic out_free;
    } stat_t;

endpackage

### sv/rws_ctrl.sv
// Controller state machine for the roulette wheel selector.
// Depends on rws_pkg; drives rws_datapath through cmd_t and reads stat_t.

module rws_ctrl
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    input  logic [rws_pkg::REQ_W-1:0]    req_type,
    input  rws_pkg::stat_t               stat,
    output logic                         s_tready,
    output rws_pkg::cmd_t                cmd
);

    rws_pkg::state_t state_reg;
    rws_pkg::state_t state_next;
    logic            accept;

    assign s_tready = (state_reg == rws_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            rws_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (rws_pkg::req_t'(req_type))
                        rws_pkg::REQ_CLEAR:
                        begin
                            cmd.clear = 1'b1;
                        end
                        rws_pkg::REQ_APPEND:
                        begin
                            cmd.append = 1'b1;
                        end
                        rws_pkg::REQ_SELECT:
                        begin
                            cmd.start  = 1'b1;
                            state_next = rws_pkg::ST_SCAN;
                        end
                        default:
                        begin
                            cmd = '0;
                        end
                    endcase
                end
            end
            rws_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.hit || stat.exhausted)
                begin
                    state_next = rws_pkg::ST_FINISH;
                end
            end
            rws_pkg::ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = rws_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rws_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rws_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### sv/rws_datapath.sv
// Datapath for the roulette wheel selector: fitness memory, live bits,
// running total, threshold multiplier, scan accumulator and output register.
// Depends on rws_pkg; commanded by rws_ctrl.

module rws_datapath
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  rws_pkg::cmd_t                     cmd,
    input  logic [rws_pkg::FIT_W-1:0]         fitness_value,
    input  logic [rws_pkg::RAND_W-1:0]        random_word,
    input  logic                              m_tready,
    output rws_pkg::stat_t                    stat,
    output logic                              m_tvalid,
    output logic [rws_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                              m_tuser
);

    logic [rws_pkg::FIT_W-1:0]    mem [rws_pkg::MAX_ENTRIES];
    logic [rws_pkg::FIT_W-1:0]    rd_data_reg;

    logic [rws_pkg::CNT_W-1:0]    count_reg,   count_next;
    logic [rws_pkg::TOT_W-1:0]    total_reg,   total_next;
    logic [rws_pkg::MAX_ENTRIES-1:0] live_reg, live_next;
    logic [rws_pkg::CNT_W-1:0]    addr_reg,    addr_next;
    logic                         pend_vld_reg, pend_vld_next;
    logic [rws_pkg::IDX_W-1:0]    pend_idx_reg;
    logic [rws_pkg::PROD_W-1:0]   prod_reg;
    logic [rws_pkg::TOT_W-1:0]    sum_reg,     sum_next;
    logic                         found_reg;
    logic [rws_pkg::IDX_W-1:0]    idx_reg;
    logic [rws_pkg::FIT_W-1:0]    fit_reg;
    logic                         m_tvalid_reg, m_tvalid_next;
    logic [rws_pkg::PICK_W-1:0]   out_idx_reg;
    logic                         out_found_reg;

    logic                         full;
    logic                         do_append;
    logic                         issue;
    logic                         cand;
    logic [rws_pkg::TOT_W:0]      sum_ext;
    logic [rws_pkg::TOT_W-1:0]    thr;

    assign full      = (count_reg == rws_pkg::CNT_W'(rws_pkg::MAX_ENTRIES));
    assign do_append = cmd.append && !full;
    assign issue     = cmd.scan && (addr_reg < count_reg);
    assign cand      = pend_vld_reg && live_reg[pend_idx_reg];
    assign sum_ext   = {1'b0, sum_reg} + (rws_pkg::TOT_W + 1)'(rd_data_reg);
    assign thr       = prod_reg[rws_pkg::PROD_W-1:rws_pkg::RAND_W];

    assign stat.hit       = cand && (sum_ext > {1'b0, thr});
    assign stat.exhausted = (addr_reg >= count_reg) && !pend_vld_reg;
    assign stat.out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(rws_pkg::OUT_DATA_W - rws_pkg::PICK_W){1'b0}}, out_idx_reg};
    assign m_tuser  = out_found_reg;

    always_comb
    begin
        count_next    = count_reg;
        total_next    = total_reg;
        live_next     = live_reg;
        addr_next     = addr_reg;
        pend_vld_next = pend_vld_reg;
        sum_next      = sum_reg;
        m_tvalid_next = m_tvalid_reg;

        if (cmd.clear)
        begin
            count_next = '0;
            total_next = '0;
            live_next  = '0;
        end
        else if (do_append)
        begin
            count_next = count_reg + rws_pkg::CNT_W'(1);
            total_next = total_reg + rws_pkg::TOT_W'(fitness_value);
            live_next[count_reg[rws_pkg::IDX_W-1:0]] = 1'b1;
        end
        else if (cmd.commit && found_reg)
        begin
            total_next = total_reg - rws_pkg::TOT_W'(fit_reg);
            live_next[idx_reg] = 1'b0;
        end

        if (cmd.start)
        begin
            addr_next     = '0;
            pend_vld_next = 1'b0;
            sum_next      = '0;
        end
        else if (cmd.scan)
        begin
            pend_vld_next = issue;
            if (issue)
            begin
                addr_next = addr_reg + rws_pkg::CNT_W'(1);
            end
            if (cand)
            begin
                sum_next = sum_ext[rws_pkg::TOT_W-1:0];
            end
        end

        if (cmd.commit)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_append)
        begin
            mem[count_reg[rws_pkg::IDX_W-1:0]] <= fitness_value;
        end
        rd_data_reg <= mem[addr_reg[rws_pkg::IDX_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            total_reg    <= '0;
            live_reg     <= '0;
            addr_reg     <= '0;
            pend_vld_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            total_reg    <= total_next;
            live_reg     <= live_next;
            addr_reg     <= addr_next;
            pend_vld_reg <= pend_vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg <= addr_reg[rws_pkg::IDX_W-1:0];
        sum_reg      <= sum_next;
        if (cmd.start)
        begin
            prod_reg <= rws_pkg::PROD_W'(random_word) * rws_pkg::PROD_W'(total_reg);
        end
        if (cmd.scan && (stat.hit || stat.exhausted))
        begin
            found_reg <= stat.hit;
            idx_reg   <= pend_idx_reg;
            fit_reg   <= rd_data_reg;
        end
        if (cmd.commit)
        begin
            out_idx_reg   <= found_reg ? rws_pkg::PICK_W'(idx_reg) : '0;
            out_found_reg <= found_reg;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= rws_pkg::CNT_W'(rws_pkg::MAX_ENTRIES))
        else $error("entry count beyond pool size");

    a_empty_total: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (total_reg == '0))
        else $error("nonzero total with empty pool");

    a_commit_live: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && found_reg) |-> live_reg[idx_reg])
        else $error("removing an entry that is not live");

    a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> m_tvalid_reg)
        else $error("result not presented after commit");

    a_hit_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.scan && stat.hit) |-> (pend_vld_reg && (total_reg != '0)))
        else $error("hit without a pending live entry");
`endif

endmodule

### sv/roulette_wheel_selector.sv
// Roulette wheel selector, top level.
// Depends on rws_pkg, rws_ctrl and rws_datapath.
//
// Usage:
//   Input channel s_*: one request per transfer. s_tuser carries the request
//   kind (clear, append, select). Clear and append finish in the accepting
//   cycle and produce no result; an append to a full pool (64 entries) is
//   dropped. A select produces exactly one transfer on m_*.
//   Output channel m_*: m_tdata carries the picked index, m_tuser the found
//   flag; index reads zero when nothing was found.
// Operation:
//   Clear and append can be accepted back to back. A select runs, in order:
//   the threshold multiply in the accepting cycle, a memory read of each
//   loaded entry in load order, the registered read data, detection of the
//   end of the pool, and an update of the pool with the load of the output
//   register, which waits while the receiver stalls. The scan stops early at
//   the picked entry.
// Reset clears the pool, the total and the output valid flag.
// If the receiver stalls, the result holds in the output register; a new
// request is still taken, and a later select waits before its update cycle.

module roulette_wheel_selector
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rws_pkg::IN_DATA_W-1:0]     s_tdata,   // fitness_value[15:0], random_word[47:16]
    input  logic [rws_pkg::REQ_W-1:0]         s_tuser,   // req_type[1:0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [rws_pkg::OUT_DATA_W-1:0]    m_tdata,   // picked_index[5:0], zero[7:6]
    output logic                              m_tuser    // found[0]
);

    rws_pkg::cmd_t  cmd;
    rws_pkg::stat_t stat;

    rws_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .req_type (s_tuser),
        .stat     (stat),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    rws_datapath u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .fitness_value (s_tdata[rws_pkg::FIT_W-1:0]),
        .random_word   (s_tdata[rws_pkg::FIT_W +: rws_pkg::RAND_W]),
        .m_tready      (m_tready),
        .stat          (stat),
        .m_tvalid      (m_tvalid),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser)
    );

endmodule
